// ===== sv/tsl_pkg.sv =====
// Shared types and constants for the transfer speed limiter.
// Used by tsl_div, transfer_speed_limiter and its checker; no dependencies.
`default_nettype none
package tsl_pkg;

  localparam int DVD_W      = 64;  // divider dividend / quotient width
  localparam int DVS_W      = 34;  // divider divisor width
  localparam int HIGH_LIMIT = 1048576;
  localparam int BRAKE_DIV  = 8;
  localparam int MS_PER_S   = 1000;
  localparam int SLEEP_CAP  = 1000;
  localparam int IDEAL_CAP  = 10000;

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_USE_SPEED_LIMIT    = 2'd0,
    REG_SPEED_LIMIT        = 2'd1,
    REG_USE_PROGRESS_LIMIT = 2'd2,
    REG_PROGRESS_LIMIT     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_GO,
    ST_WAIT
  } state_t;

  typedef enum logic [2:0] {
    STP_FP_SPB,
    STP_FP_SLP,
    STP_TR_FROM,
    STP_TR_IDEAL,
    STP_TR_SPB,
    STP_PL_SLP
  } step_t;

endpackage
`default_nettype wire

// ===== sv/tsl_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all limiter steps.
// Depends on tsl_pkg for default widths.
`default_nettype none
module tsl_div #(
  parameter int DVD_W = tsl_pkg::DVD_W,
  parameter int DVS_W = tsl_pkg::DVS_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             qbit;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== sv/transfer_speed_limiter.sv =====
// Byte-rate limiter: one word in, one result word out, computed by a sequencer
// around a single 32x32 multiplier and the shared bit-serial divider tsl_div.
// Words needing no division (restart, unlimited, unthrottled) finish in EVAL; each
// division adds a pass through GO and WAIT, one or two on a first packet and two or
// three on a recompute. The next word is taken from IDLE once the result is taken.
// Reset (rst_n, synchronous, active low) initialises control, config and limiter state.
`default_nettype none
module transfer_speed_limiter #(
  parameter int DVD_W = tsl_pkg::DVD_W,
  parameter int DVS_W = tsl_pkg::DVS_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // byte_count[31:0], buffer_size[62:32], now_ms[110:63], zero pad
  input  wire logic [tsl_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[0], progress_only[1]
  input  wire logic [tsl_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // sleep_ms[9:0], limit_buffer_size[40:10], meter_bytes[72:41], zero pad
  output logic [tsl_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tsl_pkg::*;

  // configuration
  logic        use_sl_r, use_pl_r;
  logic [31:0] sl_cfg_r, pbl_r;
  // limiter state
  logic        first_r, first_nxt;
  logic [31:0] spb_r, spb_nxt;
  logic [31:0] last_r, last_nxt;
  logic [47:0] setup_r, setup_nxt;
  logic [33:0] bss_r, bss_nxt;
  // captured word
  logic        cmd_r, po_r;
  logic [31:0] bc_r;
  logic [30:0] bs_r;
  logic [47:0] now_r;
  // work registers
  logic [47:0] elap_r, elap_nxt;
  logic [33:0] sum_r, sum_nxt;
  logic [9:0]  from_r, from_nxt;
  logic [31:0] t_r, t_nxt;
  step_t       step_r, step_nxt;
  state_t      state_r, state_nxt;
  // result
  logic [9:0]  sleep_r, sleep_nxt;
  logic [30:0] lim_r, lim_nxt;
  logic [31:0] meter_r, meter_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic              in_acc;
  logic [31:0]       sl;
  logic              high;
  logic [30:0]       clamp_v;
  logic [47:0]       d_el;
  logic [34:0]       sum_w;
  logic [33:0]       sum_m;
  logic              brake, trig;
  logic [31:0]       ll_old, ll_new;
  logic              go, fin;
  step_t             go_step;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;
  logic [13:0]       ideal_v;
  logic signed [50:0] diff_s, total_s;
  logic [9:0]        tr_sleep;

  function automatic logic [9:0] cap_sleep(input logic [DVD_W-1:0] v);
    return (v > DVD_W'(SLEEP_CAP)) ? 10'(SLEEP_CAP) : v[9:0];
  endfunction

  function automatic logic [31:0] cap32(input logic [DVD_W-1:0] v);
    return (v > DVD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign sl     = (sl_cfg_r == 32'd0) ? 32'd1 : sl_cfg_r;
  assign high   = (sl >= 32'(HIGH_LIMIT));

  always_comb begin
    if (use_sl_r && (sl < {1'b0, bs_r})) begin
      clamp_v = (use_pl_r && (pbl_r < sl)) ? pbl_r[30:0] : sl[30:0];
    end else begin
      clamp_v = (use_pl_r && (pbl_r < {1'b0, bs_r})) ? pbl_r[30:0] : bs_r;
    end
  end

  assign d_el   = now_r - setup_r;
  assign sum_w  = {1'b0, bss_r} + {3'b0, bc_r};
  assign sum_m  = sum_w[33:0];
  // sum >= floor(sl / BRAKE_DIV)  <=>  BRAKE_DIV * (sum + 1) > sl
  assign brake  = (48'(sum_m) * 48'(BRAKE_DIV) + 48'(BRAKE_DIV)) > 48'(sl);
  assign trig   = (!d_el[47] && (d_el >= 48'(MS_PER_S))) ||
                  (sum_m >= {2'b0, sl}) || (high && brake);
  assign ll_old = (last_r == 32'd0) ? 32'd1 : last_r;
  assign ll_new = (lim_r == 31'd0) ? 32'd1 : {1'b0, lim_r};

  // recompute tail: ideal sleep, elapsed offset and total budget
  assign ideal_v  = (div_q > DVD_W'(IDEAL_CAP)) ? 14'(IDEAL_CAP) : div_q[13:0];
  assign diff_s   = $signed({37'b0, ideal_v}) - $signed({{3{elap_r[47]}}, elap_r});
  assign total_s  = diff_s + $signed({41'b0, from_r});
  assign tr_sleep = (diff_s <= 51'sd0) ? 10'd0 :
                    (diff_s > 51'(SLEEP_CAP)) ? 10'(SLEEP_CAP) : diff_s[9:0];

  // sequencing decisions shared by next-state and datapath
  always_comb begin
    go      = 1'b0;
    fin     = 1'b0;
    go_step = step_r;
    case (state_r)
      ST_EVAL: begin
        if (cmd_r || po_r || (bc_r == 32'd0) || !use_sl_r) begin
          fin = 1'b1;
        end else if (first_r) begin
          if (high) begin
            fin = 1'b1;
          end else begin
            go = 1'b1; go_step = STP_FP_SPB;
          end
        end else if (trig) begin
          go = 1'b1; go_step = STP_TR_FROM;
        end else if (spb_r != 32'd0) begin
          go = 1'b1; go_step = STP_PL_SLP;
        end else begin
          fin = 1'b1;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          case (step_r)
            STP_FP_SPB: begin
              if (bc_r > sl) begin
                fin = 1'b1;
              end else begin
                go = 1'b1; go_step = STP_FP_SLP;
              end
            end
            STP_TR_FROM: begin
              go = 1'b1; go_step = STP_TR_IDEAL;
            end
            STP_TR_IDEAL: begin
              if (!high && (total_s > 51'sd0)) begin
                go = 1'b1; go_step = STP_TR_SPB;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = fin ? ST_IDLE : ST_GO;
      ST_GO:   state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (fin) state_nxt = ST_IDLE;
        else if (go) state_nxt = ST_GO;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier and divider
  always_comb begin
    mul_a   = spb_r;
    mul_b   = bc_r;
    div_dvd = '0;
    div_dvs = DVS_W'(ll_old);
    case (step_r)
      STP_FP_SPB: begin
        div_dvd = DVD_W'(64'(lim_r) * 64'(MS_PER_S));
        div_dvs = DVS_W'(sl);
      end
      STP_FP_SLP: begin
        div_dvd = DVD_W'(prod);
        div_dvs = DVS_W'(ll_new);
      end
      STP_TR_FROM: begin
        mul_b   = bss_r[31:0];
        div_dvd = DVD_W'(prod);
      end
      STP_TR_IDEAL: begin
        div_dvd = DVD_W'(64'(sum_r) * 64'(MS_PER_S) + 64'(sl) - 64'd1);
        div_dvs = DVS_W'(sl);
      end
      STP_TR_SPB: begin
        mul_a   = t_r;
        mul_b   = last_r;
        div_dvd = DVD_W'(prod);
        div_dvs = DVS_W'(sum_r);
      end
      STP_PL_SLP: div_dvd = DVD_W'(prod);
      default: ;
    endcase
  end

  assign prod      = 64'(mul_a) * 64'(mul_b);
  assign div_start = (state_r == ST_GO);

  tsl_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // datapath updates
  always_comb begin
    first_nxt     = first_r;
    spb_nxt       = spb_r;
    last_nxt      = last_r;
    setup_nxt     = setup_r;
    bss_nxt       = bss_r;
    elap_nxt      = elap_r;
    sum_nxt       = sum_r;
    from_nxt      = from_r;
    t_nxt         = t_r;
    step_nxt      = go ? go_step : step_r;
    sleep_nxt     = sleep_r;
    lim_nxt       = lim_r;
    meter_nxt     = meter_r;
    out_valid_nxt = fin ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    case (state_r)
      ST_EVAL: begin
        sleep_nxt = 10'd0;
        lim_nxt   = 31'd0;
        meter_nxt = (use_sl_r && (bc_r > sl)) ? sl : bc_r;
        if (cmd_r) begin
          meter_nxt = 32'd0;
          if (use_sl_r) begin
            first_nxt = 1'b1;
            setup_nxt = now_r;
            bss_nxt   = '0;
          end
        end else if (po_r || (bc_r == 32'd0)) begin
          meter_nxt = bc_r;
        end else if (!use_sl_r) begin
          lim_nxt = clamp_v;
        end else if (first_r) begin
          lim_nxt   = clamp_v;
          last_nxt  = {1'b0, clamp_v};
          first_nxt = 1'b0;
          if (high) begin
            spb_nxt = 32'd0;
            bss_nxt = {2'b0, bc_r};
          end else begin
            bss_nxt = '0;
          end
        end else if (trig) begin
          elap_nxt = d_el;
          sum_nxt  = sum_m;
        end else begin
          bss_nxt = sum_m;
          lim_nxt = (last_r < {1'b0, bs_r}) ? last_r[30:0] : bs_r;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          case (step_r)
            STP_FP_SPB: begin
              spb_nxt = cap32(div_q);
              if (bc_r > sl) begin
                sleep_nxt = 10'(SLEEP_CAP);
                setup_nxt = now_r + 48'(SLEEP_CAP);
              end else begin
                setup_nxt = now_r;
              end
            end
            STP_FP_SLP: begin
              sleep_nxt = cap_sleep(div_q);
              setup_nxt = now_r + 48'(cap_sleep(div_q));
            end
            STP_TR_FROM: from_nxt = cap_sleep(div_q);
            STP_TR_IDEAL: begin
              sleep_nxt = tr_sleep;
              lim_nxt   = clamp_v;
              last_nxt  = {1'b0, clamp_v};
              setup_nxt = now_r + 48'(tr_sleep);
              bss_nxt   = '0;
              spb_nxt   = 32'd0;
              t_nxt     = (total_s > 51'sd4294967295) ? 32'hFFFF_FFFF : total_s[31:0];
            end
            STP_TR_SPB: spb_nxt = cap32(div_q);
            STP_PL_SLP: sleep_nxt = cap_sleep(div_q);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_sl_r    <= 1'b0;
      sl_cfg_r    <= 32'd1;
      use_pl_r    <= 1'b0;
      pbl_r       <= 32'd32768;
      first_r     <= 1'b0;
      spb_r       <= 32'd0;
      last_r      <= 32'd1;
      setup_r     <= '0;
      bss_r       <= '0;
      state_r     <= ST_IDLE;
      step_r      <= STP_FP_SPB;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_USE_SPEED_LIMIT:    use_sl_r <= cfg_wdata[0];
          REG_SPEED_LIMIT:        sl_cfg_r <= cfg_wdata;
          REG_USE_PROGRESS_LIMIT: use_pl_r <= cfg_wdata[0];
          REG_PROGRESS_LIMIT:     pbl_r    <= cfg_wdata;
          default: ;
        endcase
      end
      first_r     <= first_nxt;
      spb_r       <= spb_nxt;
      last_r      <= last_nxt;
      setup_r     <= setup_nxt;
      bss_r       <= bss_nxt;
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      bc_r  <= in_tdata[31:0];
      bs_r  <= in_tdata[62:32];
      now_r <= in_tdata[110:63];
      cmd_r <= in_tuser[0];
      po_r  <= in_tuser[1];
    end
    elap_r  <= elap_nxt;
    sum_r   <= sum_nxt;
    from_r  <= from_nxt;
    t_r     <= t_nxt;
    sleep_r <= sleep_nxt;
    lim_r   <= lim_nxt;
    meter_r <= meter_nxt;
  end

  // hold a finished word until taken before admitting the next one
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, meter_r, lim_r, sleep_r};

endmodule
`default_nettype wire

// ===== sv/tsl_checker.sv =====
// Port-level checks for transfer_speed_limiter, bound to the top level.
// Depends on tsl_pkg for port widths.
`default_nettype none
module tsl_sva (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [tsl_pkg::IN_DATA_W-1:0]   in_tdata,
  input wire logic [tsl_pkg::IN_USER_W-1:0]   in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tsl_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tsl_pkg::*;

  // one word in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after accept");

  // no stale result is left pending once a new word is taken
  a_out_clear_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result pending after new word accepted");

  a_sleep_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:0] <= 10'(SLEEP_CAP)))
    else $error("sleep_ms above cap");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

endmodule

bind transfer_speed_limiter tsl_sva u_tsl_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
